// ===== design/fmt_pkg.sv =====
// Package for the Fibonacci membership test: widths, constants and pipeline depth.
package fmt_pkg;

  // Low bits of the input value that take part in the test.
  localparam int VALUE_BITS = 24;

  // x*x, then 5*x*x + 4 (factor 5 is below 8, so three more bits are enough).
  localparam int SQ_BITS    = 2 * VALUE_BITS;
  localparam int N_BITS     = SQ_BITS + 3;
  // Floor root of an N_BITS operand; one root bit is resolved per sqrt stage.
  localparam int ROOT_BITS  = (N_BITS + 1) / 2;
  // Trial subtrahend carries one guard bit above the operand.
  localparam int TRIAL_BITS = N_BITS + 1;

  // Square stage, candidate stage, ROOT_BITS sqrt stages, result stage.
  localparam int LATENCY    = ROOT_BITS + 3;

  // Offset in the test 5*x*x +/- 4.
  localparam logic [N_BITS-1:0] FIB_OFFSET = N_BITS'(4);

endpackage

// ===== design/fibonacci_membership_test_top.sv =====
// Top level of the Fibonacci membership test: pipelined exact square-root test.
//
// Use: drive in_value and pulse start. An item is taken at every rising edge
// where start is high and busy is low; busy is never raised, so a new value
// can enter in every cycle.
// Each item leaves as one result: out_valid is high for exactly one cycle and
// out_is_fib is 1 when the value is a Fibonacci number, else 0.
// Only the low VALUE_BITS bits of in_value are tested.
// Method: x is a Fibonacci number when 5x^2+4 or 5x^2-4 is a perfect square.
// Both candidates pass down a restoring square-root pipeline that settles one
// root bit per stage; the remainder is zero exactly for a perfect square.
// For x = 0 the minus form is ignored.
// From acceptance to out_valid an item passes one square stage, one candidate
// stage, one stage per root bit and one result stage. Throughput: one item per
// cycle, set by the one-bit-per-stage square-root pipeline.
// Reset (rst_n low, synchronous) clears every valid bit, dropping items in
// flight; the data registers are left as they are. The receiver cannot stall:
// results are shown once and never held back.
module fibonacci_membership_test_top
  import fmt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  output logic                  out_is_fib
);

  // Square stage: register x*x and whether x is non-zero.
  logic                 sq_vld_r;
  logic                 sq_nz_r;
  logic [SQ_BITS-1:0]   sq_r;
  logic [SQ_BITS-1:0]   sq_nxt;

  // Square-root stages; index 0 holds the candidates, index ROOT_BITS the end.
  logic                 rt_vld_r [ROOT_BITS+1];
  logic                 rt_nz_r  [ROOT_BITS+1];
  logic [N_BITS-1:0]    rem_p_r  [ROOT_BITS+1];
  logic [N_BITS-1:0]    rem_m_r  [ROOT_BITS+1];
  logic [ROOT_BITS-1:0] root_p_r [ROOT_BITS+1];
  logic [ROOT_BITS-1:0] root_m_r [ROOT_BITS+1];

  logic [N_BITS-1:0]    five_sq;
  logic                 out_valid_r;
  logic                 out_is_fib_r;
  logic                 out_is_fib_nxt;

  // Never hold off the sender: every stage advances in every cycle.
  assign busy = 1'b0;

  assign sq_nxt = SQ_BITS'(in_value) * SQ_BITS'(in_value);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
    end else begin
      sq_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    sq_r    <= sq_nxt;
    sq_nz_r <= (in_value != '0);
  end

  // 5*x*x as 4*x*x + x*x; keep the wrapped minus form, masked later for x = 0.
  assign five_sq = (N_BITS'(sq_r) << 2) + N_BITS'(sq_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rt_vld_r[0] <= 1'b0;
    end else begin
      rt_vld_r[0] <= sq_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    rt_nz_r[0]  <= sq_nz_r;
    rem_p_r[0]  <= five_sq + FIB_OFFSET;
    rem_m_r[0]  <= five_sq - FIB_OFFSET;
    root_p_r[0] <= '0;
    root_m_r[0] <= '0;
  end

  // One root bit per stage, most significant first.
  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_root
    localparam int BitPos = ROOT_BITS - 1 - k;

    logic [TRIAL_BITS-1:0] trial_p;
    logic [TRIAL_BITS-1:0] trial_m;
    logic                  take_p;
    logic                  take_m;
    logic [N_BITS-1:0]     rem_p_nxt;
    logic [N_BITS-1:0]     rem_m_nxt;
    logic [ROOT_BITS-1:0]  root_p_nxt;
    logic [ROOT_BITS-1:0]  root_m_nxt;

    // Trial = (root << (bit+1)) + 4^bit; root only has bits above this one.
    assign trial_p = (TRIAL_BITS'(root_p_r[k]) << (BitPos + 1))
                   + (TRIAL_BITS'(1) << (2 * BitPos));
    assign trial_m = (TRIAL_BITS'(root_m_r[k]) << (BitPos + 1))
                   + (TRIAL_BITS'(1) << (2 * BitPos));

    assign take_p = TRIAL_BITS'(rem_p_r[k]) >= trial_p;
    assign take_m = TRIAL_BITS'(rem_m_r[k]) >= trial_m;

    assign rem_p_nxt  = take_p ? rem_p_r[k] - trial_p[N_BITS-1:0] : rem_p_r[k];
    assign rem_m_nxt  = take_m ? rem_m_r[k] - trial_m[N_BITS-1:0] : rem_m_r[k];
    assign root_p_nxt = take_p ? root_p_r[k] | (ROOT_BITS'(1) << BitPos) : root_p_r[k];
    assign root_m_nxt = take_m ? root_m_r[k] | (ROOT_BITS'(1) << BitPos) : root_m_r[k];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rt_vld_r[k+1] <= 1'b0;
      end else begin
        rt_vld_r[k+1] <= rt_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      rt_nz_r[k+1]  <= rt_nz_r[k];
      rem_p_r[k+1]  <= rem_p_nxt;
      rem_m_r[k+1]  <= rem_m_nxt;
      root_p_r[k+1] <= root_p_nxt;
      root_m_r[k+1] <= root_m_nxt;
    end
  end

  // A zero remainder means the candidate was a perfect square.
  assign out_is_fib_nxt = (rem_p_r[ROOT_BITS] == '0)
                       || (rt_nz_r[ROOT_BITS] && (rem_m_r[ROOT_BITS] == '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= rt_vld_r[ROOT_BITS];
    end
  end

  always_ff @(posedge clk) begin
    out_is_fib_r <= out_is_fib_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_is_fib = out_is_fib_r;

`ifndef NO_ASSERTIONS
  // Every result traces back to an item that was taken at the pipeline's entry.
  a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without a matching item");

  // Zero is a Fibonacci number through the plus form.
  a_zero_is_fib: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(in_value == '0, LATENCY) |-> out_is_fib)
    else $error("zero not reported as Fibonacci");

  // Four is not a Fibonacci number: 84 and 76 are both non-square.
  a_four_not_fib: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(in_value == VALUE_BITS'(4), LATENCY) |-> !out_is_fib)
    else $error("four reported as Fibonacci");
`endif

endmodule
